@@ rtl/core/drls_pkg.sv @@
// Package: shared types, constants and op codes for the dropout line search core.
package drls_pkg;
    localparam int DefMaxSources = 4;
    localparam int DefTableDepth = 1024;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] MODE_PAL  = 2'd0;
    localparam logic [1:0] MODE_PALM = 2'd1;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_FIRST = 3'd1;
    localparam logic [2:0] CFG_LAST  = 3'd2;
    localparam logic [2:0] CFG_INTRA = 3'd3;
    localparam logic [2:0] CFG_Q0    = 3'd4;
    localparam logic [2:0] CFG_Q1    = 3'd5;
    localparam logic [2:0] CFG_Q2    = 3'd6;
    localparam logic [2:0] CFG_Q3    = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  src_id;
        logic        field_sel;
        logic [9:0]  span_line;
        logic [11:0] span_start;
        logic [11:0] span_end;
        logic        match_chroma;
        logic        in_burst;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  rep_source;
        logic        rep_same_field;
        logic [9:0]  rep_line;
        logic [10:0] rep_distance;
        logic        table_overflow;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input beat
        logic do_load;     // append span
        logic do_clear;    // empty table
        logic pass_start;  // begin a search: set line from query line/direction
        logic scan;        // issue table read at scan index
        logic line_next;   // line busy: step to next line
        logic take;        // line clean: compare candidate
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic is_clear;
        logic is_query;
        logic in_window;   // current line searchable
        logic scan_last;   // last table entry being read
        logic table_empty;
        logic hit;         // registered read data overlaps
        logic pass_skip;   // other field forbidden
    } dp_stat_t;
endpackage

@@ rtl/core/drls_if.sv @@
// Interface: valid/ready channel carrying one beat of type T.
interface drls_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/dropout_replacement_line_search_core.sv @@
// Top level: dropout replacement line search core.
// channel | dir | beat
// in_ch   | in  | in_beat_t: op, span fields, query flags
// out_ch  | out | out_beat_t: one beat per query
// cfg     | in  | cfg_we / cfg_index / cfg_data
// A query runs MaxSources x 4 searches; each line visited reads the span
// table one entry a cycle through the single memory read port.
// Async active-low reset; the span table itself is not cleared.
// Input stalls while a result waits on out_ch.
module dropout_replacement_line_search_core
    import drls_pkg::*;
#(
    parameter int MaxSources = DefMaxSources,
    parameter int TableDepth = DefTableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    drls_if.sink        in_ch,
    drls_if.source      out_ch
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [1:0] src, dir;

    drls_ctrl #(.MaxSources(MaxSources)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat), .src(src), .dir(dir)
    );

    drls_dp #(.TableDepth(TableDepth)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(in_ch.data), .cmd(cmd), .src(src), .dir(dir),
        .stat(stat), .result(out_ch.data)
    );
endmodule

@@ rtl/core/drls_ctrl.sv @@
// Controller: sequences clear/load/query and the per-line table scan.
module drls_ctrl
    import drls_pkg::*;
#(
    parameter int MaxSources = DefMaxSources
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat,
    output logic [1:0] src,
    output logic [1:0] dir
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_PASS  = 3'd2;
    localparam logic [2:0] S_LINE  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] src_reg, src_next;
    logic [1:0] dir_reg, dir_next;
    logic       hitacc_reg, hitacc_next;
    logic       lastrd_reg, lastrd_next;

    assign src = src_reg;
    assign dir = dir_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next  = state_reg;
        src_next    = src_reg;
        dir_next    = dir_reg;
        hitacc_next = hitacc_reg;
        lastrd_next = lastrd_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                src_next = '0;
                dir_next = '0;
                if (stat.is_clear)
                begin
                    cmd.do_clear = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.is_load)
                begin
                    cmd.do_load = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.is_query)
                    state_next = S_PASS;
                else
                    state_next = S_IDLE;
            end
            S_PASS:
            begin
                cmd.pass_start = 1'b1;
                state_next     = S_LINE;
            end
            S_LINE:
            begin
                hitacc_next = 1'b0;
                lastrd_next = 1'b0;
                if (stat.pass_skip || !stat.in_window)
                    state_next = S_NEXT;
                else if (stat.table_empty)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan    = 1'b1;
                lastrd_next = stat.scan_last;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.hit || hitacc_reg)
                begin
                    cmd.line_next = 1'b1;
                    state_next    = S_LINE;
                end
                else if (lastrd_reg)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.scan    = 1'b1;
                    lastrd_next = stat.scan_last;
                end
            end
            S_NEXT:
            begin
                dir_next = dir_reg + 2'd1;
                if (dir_reg == 2'd3)
                begin
                    src_next = src_reg + 2'd1;
                    if (32'(src_reg) == MaxSources - 1)
                        state_next = S_OUT;
                    else
                        state_next = S_PASS;
                end
                else
                    state_next = S_PASS;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            src_reg    <= '0;
            dir_reg    <= '0;
            hitacc_reg <= 1'b0;
            lastrd_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            src_reg    <= src_next;
            dir_reg    <= dir_next;
            hitacc_reg <= hitacc_next;
            lastrd_reg <= lastrd_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ready)
        else $error("accepted while busy");
    a_scan_take: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take && cmd.line_next))
        else $error("take and step together");
endmodule

@@ rtl/core/drls_dp.sv @@
// Datapath: span memory, config registers, line stepping and best-candidate select.
module drls_dp
    import drls_pkg::*;
#(
    parameter int TableDepth = DefTableDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  in_beat_t   in_data,
    input  dp_cmd_t    cmd,
    input  logic [1:0] src,
    input  logic [1:0] dir,
    output dp_stat_t   stat,
    output out_beat_t  result
);
    localparam int AW = $clog2(TableDepth);
    localparam int CW = $clog2(TableDepth + 1);

    logic [1:0]  mode_reg;
    logic [9:0]  first_reg, last_reg;
    logic        intra_reg;
    logic [15:0] qual_reg [4];

    in_beat_t    q_reg;
    logic [36:0] mem [TableDepth];
    logic [36:0] rd_reg;
    logic        rdv_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic        ovf_reg;

    logic signed [12:0] line_reg;
    logic signed [12:0] step_reg;
    logic        have_reg;
    logic [10:0] bdist_reg;
    logic [15:0] bq_reg;
    logic [1:0]  bsrc_reg;
    logic        bsame_reg;
    logic [9:0]  bline_reg;

    logic        same;
    logic        cfld;
    logic [2:0]  stepv;
    logic signed [12:0] offs;
    logic signed [12:0] start;
    logic [12:0] tframe, cframe, dsum;
    logic [10:0] cand_dist;
    logic        better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            first_reg <= 10'd22;
            last_reg  <= 10'd308;
            intra_reg <= 1'b0;
            qual_reg  <= '{default: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_FIRST: first_reg <= cfg_data[9:0];
                CFG_LAST:  last_reg  <= cfg_data[9:0];
                CFG_INTRA: intra_reg <= cfg_data[0];
                CFG_Q0:    qual_reg[0] <= cfg_data;
                CFG_Q1:    qual_reg[1] <= cfg_data;
                CFG_Q2:    qual_reg[2] <= cfg_data;
                CFG_Q3:    qual_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            q_reg <= in_data;
        if (cmd.do_load && 32'(count_reg) < TableDepth)
            mem[count_reg[AW-1:0]] <= {q_reg.src_id, q_reg.field_sel, q_reg.span_line,
                                       q_reg.span_start, q_reg.span_end};
        if (cmd.scan)
            rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            rdv_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            rdv_reg <= cmd.scan;
            if (cmd.do_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.do_load)
            begin
                if (32'(count_reg) < TableDepth)
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.pass_start || cmd.line_next || cmd.take)
                idx_reg <= '0;
            else if (cmd.scan)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    assign same = !dir[1];
    assign cfld = same ? q_reg.field_sel : !q_reg.field_sel;
    always_comb
    begin
        if (!q_reg.match_chroma)
        begin
            stepv = 3'd1;
            offs  = -13'sd1;
        end
        else if (mode_reg == MODE_PAL || mode_reg == MODE_PALM)
        begin
            stepv = 3'd4;
            offs  = q_reg.field_sel ? -13'sd1 : -13'sd3;
        end
        else
        begin
            stepv = 3'd2;
            offs  = -13'sd1;
        end
        start = $signed({3'b000, q_reg.span_line}) + (same ? 13'sd0 : offs)
              + (dir[0] ? $signed({10'd0, stepv}) : 13'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
        begin
            line_reg <= start;
            step_reg <= dir[0] ? $signed({10'd0, stepv}) : -$signed({10'd0, stepv});
        end
        else if (cmd.line_next)
            line_reg <= line_reg + step_reg;
    end

    assign tframe    = {2'b00, q_reg.span_line, 1'b0} + {12'd0, q_reg.field_sel};
    assign cframe    = {line_reg[11:0], 1'b0} + {12'd0, cfld};
    assign dsum      = (tframe >= cframe) ? tframe - cframe : cframe - tframe;
    assign cand_dist = dsum[10:0];
    assign better = !have_reg || cand_dist < bdist_reg
                  || (cand_dist == bdist_reg && qual_reg[src] > bq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_reg <= 1'b0;
        else if (cmd.capture)
            have_reg <= 1'b0;
        else if (cmd.take && better)
            have_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && better)
        begin
            bdist_reg <= cand_dist;
            bq_reg    <= qual_reg[src];
            bsrc_reg  <= src;
            bsame_reg <= same;
            bline_reg <= line_reg[9:0];
        end
    end

    assign stat.is_clear    = (q_reg.op == OP_CLEAR);
    assign stat.is_load     = (q_reg.op == OP_LOAD);
    assign stat.is_query    = (q_reg.op == OP_QUERY);
    assign stat.pass_skip   = !same && (q_reg.in_burst || intra_reg);
    assign stat.in_window   = (line_reg - 13'sd1 >= $signed({3'b000, first_reg}))
                            && (line_reg < $signed({3'b000, last_reg}));
    assign stat.table_empty = (count_reg == '0);
    assign stat.scan_last   = (32'(idx_reg) + 1 >= 32'(count_reg));
    assign stat.hit = rdv_reg && rd_reg[36:35] == src && rd_reg[34] == cfld
                    && {3'b000, rd_reg[33:24]} == line_reg
                    && q_reg.span_end >= rd_reg[23:12] && rd_reg[11:0] >= q_reg.span_start;

    assign result.found          = have_reg;
    assign result.rep_source     = have_reg ? bsrc_reg : 2'd0;
    assign result.rep_same_field = have_reg ? bsame_reg : 1'b0;
    assign result.rep_line       = have_reg ? bline_reg : 10'd0;
    assign result.rep_distance   = have_reg ? bdist_reg : 11'd0;
    assign result.table_overflow = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TableDepth)
        else $error("count overran");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> 32'(count_reg) == TableDepth)
        else $error("overflow while not full");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_clear |=> count_reg == '0 && !ovf_reg)
        else $error("clear failed");
endmodule

@@ dv/tb.sv @@
// Testbench for dropout_replacement_line_search_core: directed and random beats checked against a local predictor.
`timescale 1ns / 1ps

module tb;
    import drls_pkg::*;

    localparam logic [1:0] MODE_NTSC  = 2'd2;
    localparam logic [1:0] MODE_THREE = 2'd3;
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam int Depth = DefTableDepth;
    localparam int CycleLimit = 20000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    drls_if #(.T(in_beat_t))  in_ch ();
    drls_if #(.T(out_beat_t)) out_ch ();

    dropout_replacement_line_search_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // predictor state
    logic [1:0]  tbl_src [Depth];
    logic        tbl_fld [Depth];
    logic [9:0]  tbl_line [Depth];
    logic [11:0] tbl_sx [Depth];
    logic [11:0] tbl_ex [Depth];
    int          span_count;
    bit          overflow;
    logic [1:0]  sys_mode;
    int          first_line;
    int          last_line;
    bit          intra;
    logic [15:0] quality [4];

    out_beat_t   pending_replacements[$];
    int          errors;
    int          send_idle;
    int          recv_stall;
    int          hold_cycles;
    longint      cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("dropout_replacement_line_search_core test failed");
            $finish;
        end
    end

    function automatic bit line_busy(int s, bit f, int ln, int tsx, int tex);
        for (int i = 0; i < span_count; i++)
        begin
            if (tbl_src[i] == s && tbl_fld[i] == f && tbl_line[i] == ln &&
                tex >= tbl_sx[i] && tbl_ex[i] >= tsx)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_beat_t best_replacement(in_beat_t b);
        out_beat_t r;
        int step;
        int offs;
        int tframe;
        int best_dist;
        int ln;
        int dir;
        int cand;
        int cand_dist;
        bit have;
        bit same;
        bit fld;
        logic [15:0] best_q;
        bit first;
        first = (b.field_sel == 1'b0);
        have = 1'b0;
        best_dist = 0;
        best_q = '0;
        r = '0;
        if (!b.match_chroma)
        begin
            step = 1;
            offs = -1;
        end
        else if (sys_mode == MODE_PAL || sys_mode == MODE_PALM)
        begin
            step = 4;
            offs = first ? -3 : -1;
        end
        else
        begin
            step = 2;
            offs = -1;
        end
        tframe = 2 * b.span_line + (first ? 0 : 1);
        for (int s = 0; s < DefMaxSources; s++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                same = (k < 2);
                if (!same && (b.in_burst || intra))
                    break;
                ln = b.span_line + (same ? 0 : offs) + ((k & 1) ? step : 0);
                dir = (k & 1) ? step : -step;
                fld = same ? b.field_sel : !b.field_sel;
                cand = -1;
                while (ln - 1 >= first_line && ln < last_line)
                begin
                    if (!line_busy(s, fld, ln, b.span_start, b.span_end))
                    begin
                        cand = ln;
                        break;
                    end
                    ln += dir;
                end
                if (cand < 0)
                    continue;
                cand_dist = tframe - (2 * cand + (same ? (first ? 0 : 1) : (first ? 1 : 0)));
                if (cand_dist < 0)
                    cand_dist = -cand_dist;
                if (!have || cand_dist < best_dist
                    || (cand_dist == best_dist && quality[s] > best_q))
                begin
                    have = 1'b1;
                    best_dist = cand_dist;
                    best_q = quality[s];
                    r.rep_source = s[1:0];
                    r.rep_same_field = same;
                    r.rep_line = cand[9:0];
                    r.rep_distance = best_dist[10:0];
                end
            end
        end
        r.found = have;
        r.table_overflow = overflow;
        return r;
    endfunction

    task automatic apply_beat(in_beat_t b);
        case (b.op)
            OP_CLEAR:
            begin
                span_count = 0;
                overflow = 1'b0;
            end
            OP_LOAD:
            begin
                if (span_count < Depth)
                begin
                    tbl_src[span_count] = b.src_id;
                    tbl_fld[span_count] = b.field_sel;
                    tbl_line[span_count] = b.span_line;
                    tbl_sx[span_count] = b.span_start;
                    tbl_ex[span_count] = b.span_end;
                    span_count++;
                end
                else
                    overflow = 1'b1;
            end
            OP_QUERY: pending_replacements = {pending_replacements, best_replacement(b)};
            default: ;
        endcase
    endtask

    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        apply_beat(b);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_replacements.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MODE:  sys_mode = val[1:0];
            CFG_FIRST: first_line = val[9:0];
            CFG_LAST:  last_line = val[9:0];
            CFG_INTRA: intra = val[0];
            default:   quality[2'(idx - CFG_Q0)] = val;
        endcase
    endtask

    // receiver and result check
    always @(posedge clk)
    begin
        out_beat_t exp_r;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_replacements.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_ch.data);
                errors++;
            end
            else
            begin
                exp_r = pending_replacements.pop_front();
                if (exp_r.found != out_ch.data.found)
                begin
                    $display("%0t: found exp %0d got %0d", $time, exp_r.found, out_ch.data.found);
                    errors++;
                end
                if (exp_r.rep_source != out_ch.data.rep_source)
                begin
                    $display("%0t: rep_source exp %0d got %0d", $time, exp_r.rep_source,
                             out_ch.data.rep_source);
                    errors++;
                end
                if (exp_r.rep_same_field != out_ch.data.rep_same_field)
                begin
                    $display("%0t: rep_same_field exp %0d got %0d", $time,
                             exp_r.rep_same_field, out_ch.data.rep_same_field);
                    errors++;
                end
                if (exp_r.rep_line != out_ch.data.rep_line)
                begin
                    $display("%0t: rep_line exp %0d got %0d", $time, exp_r.rep_line,
                             out_ch.data.rep_line);
                    errors++;
                end
                if (exp_r.rep_distance != out_ch.data.rep_distance)
                begin
                    $display("%0t: rep_distance exp %0d got %0d", $time, exp_r.rep_distance,
                             out_ch.data.rep_distance);
                    errors++;
                end
                if (exp_r.table_overflow != out_ch.data.table_overflow)
                begin
                    $display("%0t: table_overflow exp %0d got %0d", $time,
                             exp_r.table_overflow, out_ch.data.table_overflow);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic in_beat_t make_beat(logic [1:0] op, logic [1:0] s, bit f, int ln,
                                           int sx, int ex, bit chroma, bit burst);
        in_beat_t b;
        b.op = op;
        b.src_id = s;
        b.field_sel = f;
        b.span_line = ln[9:0];
        b.span_start = sx[11:0];
        b.span_end = ex[11:0];
        b.match_chroma = chroma;
        b.in_burst = burst;
        return b;
    endfunction

    task automatic test_directed();
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 100, 0, 4095, 1'b0, 1'b0));
        send_beat(make_beat(OP_LOAD, 2'd0, 1'b0, 100, 10, 20, 1'b0, 1'b0));
        send_beat(make_beat(OP_LOAD, 2'd0, 1'b0, 99, 20, 30, 1'b0, 1'b0));
        send_beat(make_beat(OP_LOAD, 2'd1, 1'b1, 98, 0, 4095, 1'b0, 1'b0));
        send_beat(make_beat(OP_LOAD, 2'd3, 1'b1, 99, 15, 15, 1'b0, 1'b0));
        send_beat(make_beat(OP_LOAD, 2'd2, 1'b0, 1023, 4095, 0, 1'b1, 1'b1));
        for (int m = 0; m < 4; m++)
        begin
            wait_drained();
            write_cfg(CFG_MODE, 16'(m));
            for (int c = 0; c < 4; c++)
            begin
                send_beat(make_beat(OP_QUERY, 2'd3, c[0], 100, 12, 25, c[1], 1'b0));
            end
        end
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 100, 12, 25, 1'b1, 1'b1));
        send_beat(make_beat(OP_NONE, 2'd0, 1'b0, 100, 12, 25, 1'b1, 1'b1));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b1, 1023, 4095, 4095, 1'b1, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
        wait_drained();
        write_cfg(CFG_INTRA, 16'd1);
        write_cfg(CFG_Q1, 16'hFFFF);
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 100, 12, 25, 1'b0, 1'b0));
        send_beat(make_beat(OP_CLEAR, 2'd0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b1, 200, 12, 25, 1'b0, 1'b0));
    endtask

    task automatic random_config(int pick);
        wait_drained();
        write_cfg(CFG_MODE, 16'($urandom_range(3)));
        write_cfg(CFG_INTRA, 16'($urandom_range(1)));
        case (pick)
            0:
            begin
                write_cfg(CFG_FIRST, 16'd0);
                write_cfg(CFG_LAST, 16'd1023);
            end
            1:
            begin
                write_cfg(CFG_FIRST, 16'd1023);
                write_cfg(CFG_LAST, 16'd0);
            end
            default:
            begin
                write_cfg(CFG_FIRST, 16'($urandom_range(10, 60)));
                write_cfg(CFG_LAST, 16'($urandom_range(200, 400)));
            end
        endcase
        for (int q = 0; q < 4; q++)
        begin
            case ($urandom_range(2))
                0: write_cfg(CFG_Q0 + 3'(q), 16'd0);
                1: write_cfg(CFG_Q0 + 3'(q), 16'hFFFF);
                default: write_cfg(CFG_Q0 + 3'(q), 16'($urandom_range(3, 8) * 256));
            endcase
        end
    endtask

    // a cluster of spans around one line, then queries into it
    task automatic send_cluster(int n_query);
        int ln;
        int sx;
        int ex;
        bit f;
        ln = $urandom_range(30, 290);
        sx = $urandom_range(4095);
        ex = sx + $urandom_range(200);
        if (ex > 4095)
            ex = 4095;
        f = $urandom_range(1);
        if ($urandom_range(5) == 0)
            send_beat(make_beat(OP_CLEAR, 2'($urandom), 1'($urandom), $urandom_range(1023),
                                $urandom_range(4095), $urandom_range(4095), 1'($urandom),
                                1'($urandom)));
        send_beat(make_beat(OP_LOAD, 2'($urandom), f, ln, sx, ex, 1'b0, 1'b0));
        repeat ($urandom_range(1, 6))
        begin
            send_beat(make_beat(OP_LOAD, 2'($urandom), 1'($urandom),
                                ln + $urandom_range(8) - 4,
                                sx + $urandom_range(60) - 30, ex + $urandom_range(60) - 30,
                                1'($urandom), 1'($urandom)));
        end
        repeat (n_query)
        begin
            if ($urandom_range(7) == 0)
                send_beat(make_beat(2'($urandom), 2'($urandom), 1'($urandom),
                                    $urandom_range(1023), $urandom_range(4095),
                                    $urandom_range(4095), 1'($urandom), 1'($urandom)));
            else
                send_beat(make_beat(OP_QUERY, 2'($urandom), f, ln, sx, ex, 1'($urandom),
                                    ($urandom_range(3) == 0)));
        end
    endtask

    task automatic test_random();
        int phase_idle[4] = '{0, 75, 0, 38};
        int phase_stall[4] = '{0, 0, 75, 38};
        send_beat(make_beat(OP_CLEAR, 2'd0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
        for (int p = 0; p < 4; p++)
        begin
            send_idle = phase_idle[p];
            recv_stall = phase_stall[p];
            random_config(p);
            repeat (3)
                send_cluster($urandom_range(1, 4));
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    task automatic test_pressure();
        hold_cycles = 600;
        repeat (8)
            send_beat(make_beat(OP_QUERY, 2'($urandom), 1'($urandom), $urandom_range(30, 290),
                                $urandom_range(4095), $urandom_range(4095), 1'($urandom),
                                1'($urandom)));
        wait_drained();
        send_cluster(3);
    endtask

    // a column of fully busy lines that the searches must walk through
    task automatic test_busy_column();
        wait_drained();
        write_cfg(CFG_FIRST, 16'd22);
        write_cfg(CFG_LAST, 16'd308);
        send_beat(make_beat(OP_CLEAR, 2'd0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
        for (int ln = 142; ln < 158; ln++)
            send_beat(make_beat(OP_LOAD, 2'd0, 1'b0, ln, 0, 4095, 1'b0, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 150, 100, 200, 1'b0, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 150, 100, 200, 1'b1, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b1, 150, 0, 4095, 1'b0, 1'b1));
        send_beat(make_beat(OP_CLEAR, 2'd0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
        send_beat(make_beat(OP_QUERY, 2'd0, 1'b0, 150, 0, 4095, 1'b0, 1'b0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        errors = 0;
        hold_cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        span_count = 0;
        overflow = 1'b0;
        sys_mode = MODE_PAL;
        first_line = 22;
        last_line = 308;
        intra = 1'b0;
        for (int q = 0; q < 4; q++)
            quality[q] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_pressure();
        test_busy_column();
        wait_drained();
        if (errors == 0)
            $display("dropout_replacement_line_search_core test passed");
        else
            $display("dropout_replacement_line_search_core test failed");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/drls_pkg.sv
rtl/core/drls_if.sv
rtl/core/drls_ctrl.sv
rtl/core/drls_dp.sv
rtl/core/dropout_replacement_line_search_core.sv
dv/tb.sv
